FILE: rtl/uwr_pkg.sv
// Shared types and constants for the uniform grid ray walker.
package uwr_pkg;

  localparam int REG_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int DIMS_W   = 15;
  localparam int DIM_FLD_W = 5;
  localparam int T_W      = 64;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_LO_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LO_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LO_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HI_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HI_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HI_Z  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_DIMS = 3'd6;

  localparam logic signed [T_W-1:0] T_INF = 64'sh4000_0000_0000_0000;

  typedef enum logic [1:0] {
    DIV_SLAB_LO = 2'd0,
    DIV_SLAB_HI = 2'd1,
    DIV_CELL    = 2'd2,
    DIV_DT      = 2'd3
  } div_sel_e;

  typedef struct packed {
    logic       load;
    logic       set_inf;
    logic       div_start;
    div_sel_e   sel;
    logic       wr_a;
    logic       wr_slab;
    logic       wr_te;
    logic       mul_lo;
    logic       mul_hi;
    logic       wr_off;
    logic       cur_zero;
    logic       wr_cur;
    logic       dt_idle;
    logic       wr_dt;
    logic       wr_nxt;
    logic       step;
    logic       miss;
    logic [1:0] ax;
  } dp_cmd_t;

  typedef struct packed {
    logic ax_miss;
    logic d_zero;
    logic off_pos;
    logic t_miss;
    logic div_done;
    logic walk_last;
  } dp_sts_t;

endpackage

FILE: rtl/uniform_grid_ray_walker.sv
// Top level of the uniform grid ray walker.
// One ray is taken at a time; the input stalls until the last request of the ray has
// been accepted, and the next ray can be taken in the cycle after that. Setup checks each
// axis against the box and runs two slab divisions per moving axis, then per axis a
// multiply of the low and high halves and, when the entry offset is positive, one
// division for the entry cell, then one division per moving axis for the cell spacing.
// All divisions share one divider that makes one quotient bit per cycle. The walk
// then gives one cell per cycle while the output is not stalled, at most
// 3 * MAX_CELLS_PER_AXIS - 2 cells, and a miss gives a single request.
module uniform_grid_ray_walker #(
  parameter int MAX_CELLS_PER_AXIS = 16,
  parameter int COORD_FRAC_BITS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [uwr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [uwr_pkg::REG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            origin_x_i,
  input  logic signed [31:0]            origin_y_i,
  input  logic signed [31:0]            origin_z_i,
  input  logic signed [31:0]            dir_x_i,
  input  logic signed [31:0]            dir_y_i,
  input  logic signed [31:0]            dir_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          box_hit_o,
  output logic [3:0]                    cell_x_o,
  output logic [3:0]                    cell_y_o,
  output logic [3:0]                    cell_z_o,
  output logic [11:0]                   cell_index_o,
  output logic                          last_o
);
  import uwr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  uwr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  uwr_dp #(
    .MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS),
    .COORD_FRAC_BITS    (COORD_FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .origin_x_i   (origin_x_i),
    .origin_y_i   (origin_y_i),
    .origin_z_i   (origin_z_i),
    .dir_x_i      (dir_x_i),
    .dir_y_i      (dir_y_i),
    .dir_z_i      (dir_z_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .box_hit_o    (box_hit_o),
    .cell_x_o     (cell_x_o),
    .cell_y_o     (cell_y_o),
    .cell_z_o     (cell_z_o),
    .cell_index_o (cell_index_o),
    .last_o       (last_o)
  );

`ifndef SYNTH
  a_busy_while_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while a result is pending");

  a_miss_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !box_hit_o) |-> (last_o && (cell_index_o == 12'd0)))
    else $error("miss result is not a single zero request");

  a_no_early_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result shown right after a ray was taken");
`endif

endmodule

FILE: rtl/uwr_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module uwr_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [uwr_pkg::T_W-1:0] dividend_i,
  input  logic signed [uwr_pkg::T_W-1:0] divisor_i,
  output logic                          done_o,
  output logic signed [uwr_pkg::T_W-1:0] quo_o
);
  import uwr_pkg::*;

  localparam int CNT_W = $clog2(T_W);

  logic             busy_q, busy_d, done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [T_W-1:0]   rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic             neg_q, neg_d;
  logic [T_W-1:0]   rem_sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    rem_sh = {rem_q[T_W-2:0], quo_q[T_W-1]};
    if (busy_q) begin
      if (rem_sh >= dvs_q) begin
        rem_d = rem_sh - dvs_q;
        quo_d = {quo_q[T_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[T_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(T_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i[T_W-1] ? unsigned'(-dividend_i) : unsigned'(dividend_i);
      dvs_d  = divisor_i[T_W-1] ? unsigned'(-divisor_i) : unsigned'(divisor_i);
      neg_d  = dividend_i[T_W-1] ^ divisor_i[T_W-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -signed'(quo_q) : signed'(quo_q);

endmodule

FILE: rtl/uwr_dp.sv
// Datapath of the ray walker: registers, slab and cell arithmetic, walk step logic.
module uwr_dp #(
  parameter int MAX_CELLS_PER_AXIS = 16,
  parameter int COORD_FRAC_BITS    = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [uwr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [uwr_pkg::REG_W-1:0]          cfg_data_i,
  input  logic signed [31:0]                 origin_x_i,
  input  logic signed [31:0]                 origin_y_i,
  input  logic signed [31:0]                 origin_z_i,
  input  logic signed [31:0]                 dir_x_i,
  input  logic signed [31:0]                 dir_y_i,
  input  logic signed [31:0]                 dir_z_i,
  input  uwr_pkg::dp_cmd_t                   cmd_i,
  output uwr_pkg::dp_sts_t                   sts_o,
  output logic                               box_hit_o,
  output logic [3:0]                         cell_x_o,
  output logic [3:0]                         cell_y_o,
  output logic [3:0]                         cell_z_o,
  output logic [11:0]                        cell_index_o,
  output logic                               last_o
);
  import uwr_pkg::*;

  localparam int NW     = $clog2(MAX_CELLS_PER_AXIS + 1);
  localparam int CW     = NW + 1;
  localparam int CAP    = 3 * MAX_CELLS_PER_AXIS - 2;
  localparam int CNT_W  = $clog2(CAP + 1);

  logic signed [31:0]     lo_q [3];
  logic signed [31:0]     hi_q [3];
  logic [DIMS_W-1:0]      dims_q;
  logic signed [31:0]     o_q [3];
  logic signed [31:0]     d_q [3];
  logic signed [T_W-1:0]  tmn_q [3];
  logic signed [T_W-1:0]  tmx_q [3];
  logic signed [T_W-1:0]  nxt_q [3];
  logic signed [T_W-1:0]  dt_q [3];
  logic signed [CW-1:0]   cur_q [3];
  logic signed [T_W-1:0]  ta_q, te_q, off_q;
  logic [T_W-1:0]         prod_q;
  logic [CNT_W-1:0]       cnt_q;

  logic [NW-1:0]          n [3];
  logic signed [31:0]     os, ds, los, his;
  logic [NW-1:0]          ns;
  logic signed [32:0]     dif_lo, dif_hi, dif_w;
  logic signed [T_W-1:0]  dlo64, dhi64, w64, n64, prod_s;
  logic [31:0]            dmag, mul_a;
  logic [T_W-1:0]         pp;
  logic signed [T_W-1:0]  t0, t1;
  logic signed [T_W-1:0]  div_a, div_b, quo;
  logic                   div_done;
  logic [NW-1:0]          cur_u, k;
  logic [1:0]             sax;
  logic signed [1:0]      stepv;
  logic signed [CW-1:0]   ncur;
  logic                   any_dir, out_rng, cap_hit;
  logic [31:0]            idx;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [5:0] nsum;
      nsum = 6'(dims_q[DIM_FLD_W*a +: DIM_FLD_W]) + 6'd1;
      n[a] = (32'(nsum) > MAX_CELLS_PER_AXIS) ? NW'(MAX_CELLS_PER_AXIS) : NW'(nsum);
    end
  end

  assign os  = o_q[cmd_i.ax];
  assign ds  = d_q[cmd_i.ax];
  assign los = lo_q[cmd_i.ax];
  assign his = hi_q[cmd_i.ax];
  assign ns  = n[cmd_i.ax];

  assign dif_lo = 33'(los) - 33'(os);
  assign dif_hi = 33'(his) - 33'(os);
  assign dif_w  = 33'(his) - 33'(los);
  assign dlo64  = 64'(dif_lo) <<< COORD_FRAC_BITS;
  assign dhi64  = 64'(dif_hi) <<< COORD_FRAC_BITS;
  assign w64    = 64'(dif_w) <<< COORD_FRAC_BITS;
  assign n64    = signed'(64'(ns));

  assign dmag  = ds[31] ? unsigned'(-ds) : unsigned'(ds);
  assign mul_a = cmd_i.mul_hi ? te_q[63:32] : te_q[31:0];
  assign pp    = mul_a * dmag;
  assign prod_s = ds[31] ? -signed'(prod_q) : signed'(prod_q);

  always_comb begin
    t0 = tmn_q[0];
    t1 = tmx_q[0];
    for (int a = 1; a < 3; a++) begin
      if (tmn_q[a] > t0) t0 = tmn_q[a];
      if (tmx_q[a] < t1) t1 = tmx_q[a];
    end
  end

  always_comb begin
    case (cmd_i.sel)
      DIV_SLAB_LO: begin div_a = dlo64;        div_b = 64'(ds); end
      DIV_SLAB_HI: begin div_a = dhi64;        div_b = 64'(ds); end
      DIV_CELL:    begin div_a = off_q * signed'({1'b0, ns}); div_b = w64; end
      DIV_DT:      begin
        div_a = tmx_q[cmd_i.ax] - tmn_q[cmd_i.ax];
        div_b = n64;
      end
      default:     begin div_a = dlo64;        div_b = 64'(ds); end
    endcase
  end

  uwr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  assign cur_u = NW'(unsigned'(cur_q[cmd_i.ax]));
  assign k     = ds[31] ? (ns - cur_u) : (cur_u + 1'b1);

  // Walk step: the axis whose next boundary comes first; ties go to z over x and y, and to y over x.
  always_comb begin
    if (nxt_q[0] < nxt_q[1] && nxt_q[0] < nxt_q[2]) sax = 2'd0;
    else if (nxt_q[1] < nxt_q[2])                   sax = 2'd1;
    else                                            sax = 2'd2;
    if (d_q[sax] == 32'sd0) stepv = 2'sd0;
    else if (d_q[sax][31])  stepv = -2'sd1;
    else                    stepv = 2'sd1;
    ncur    = cur_q[sax] + CW'(stepv);
    out_rng = (ncur < 0) || (ncur >= signed'(CW'(n[sax])));
    any_dir = (d_q[0] != 0) || (d_q[1] != 0) || (d_q[2] != 0);
    cap_hit = (32'(cnt_q) + 32'd1) >= CAP;
  end

  assign sts_o.ax_miss   = (his <= los) || ((ds == 32'sd0) && ((os < los) || (os > his)));
  assign sts_o.d_zero    = (ds == 32'sd0);
  assign sts_o.off_pos   = (off_q > 0);
  assign sts_o.t_miss    = (t0 > t1) || (t1 < 0);
  assign sts_o.div_done  = div_done;
  assign sts_o.walk_last = !any_dir || cap_hit || out_rng;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q[0] <= '0;
      lo_q[1] <= '0;
      lo_q[2] <= '0;
      hi_q[0] <= 32'sd65536;
      hi_q[1] <= 32'sd65536;
      hi_q[2] <= 32'sd65536;
      dims_q  <= 15'd1057;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BOX_LO_X:  lo_q[0] <= signed'(cfg_data_i);
        REG_BOX_LO_Y:  lo_q[1] <= signed'(cfg_data_i);
        REG_BOX_LO_Z:  lo_q[2] <= signed'(cfg_data_i);
        REG_BOX_HI_X:  hi_q[0] <= signed'(cfg_data_i);
        REG_BOX_HI_Y:  hi_q[1] <= signed'(cfg_data_i);
        REG_BOX_HI_Z:  hi_q[2] <= signed'(cfg_data_i);
        REG_GRID_DIMS: dims_q  <= cfg_data_i[DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      o_q[0] <= origin_x_i;
      o_q[1] <= origin_y_i;
      o_q[2] <= origin_z_i;
      d_q[0] <= dir_x_i;
      d_q[1] <= dir_y_i;
      d_q[2] <= dir_z_i;
      cnt_q  <= '0;
    end
    if (cmd_i.set_inf) begin
      tmn_q[cmd_i.ax] <= -T_INF;
      tmx_q[cmd_i.ax] <= T_INF;
    end
    if (cmd_i.wr_a) ta_q <= quo;
    if (cmd_i.wr_slab) begin
      if (ds[31]) begin
        tmn_q[cmd_i.ax] <= quo;
        tmx_q[cmd_i.ax] <= ta_q;
      end else begin
        tmn_q[cmd_i.ax] <= ta_q;
        tmx_q[cmd_i.ax] <= quo;
      end
    end
    if (cmd_i.wr_te) te_q <= (t0 > 0) ? t0 : '0;
    if (cmd_i.mul_lo) prod_q <= pp;
    if (cmd_i.mul_hi) prod_q <= prod_q + {pp[31:0], 32'd0};
    if (cmd_i.wr_off) off_q <= prod_s - dlo64;
    if (cmd_i.cur_zero) cur_q[cmd_i.ax] <= '0;
    if (cmd_i.wr_cur) begin
      if (quo > n64 - 64'sd1) cur_q[cmd_i.ax] <= signed'(CW'(ns - 1'b1));
      else                    cur_q[cmd_i.ax] <= quo[CW-1:0];
    end
    if (cmd_i.dt_idle) begin
      dt_q[cmd_i.ax]  <= '0;
      nxt_q[cmd_i.ax] <= T_INF;
    end
    if (cmd_i.wr_dt) dt_q[cmd_i.ax] <= quo;
    if (cmd_i.wr_nxt) begin
      nxt_q[cmd_i.ax] <= tmn_q[cmd_i.ax] + dt_q[cmd_i.ax] * signed'({1'b0, k});
    end
    if (cmd_i.step) begin
      cur_q[sax] <= ncur;
      nxt_q[sax] <= nxt_q[sax] + dt_q[sax];
      cnt_q      <= cnt_q + 1'b1;
    end
  end

  assign idx = 32'(unsigned'(cur_q[0]))
             + 32'(n[0]) * 32'(unsigned'(cur_q[1]))
             + 32'(n[0]) * 32'(n[1]) * 32'(unsigned'(cur_q[2]));

  assign box_hit_o    = !cmd_i.miss;
  assign cell_x_o     = cmd_i.miss ? 4'd0 : 4'(unsigned'(cur_q[0]));
  assign cell_y_o     = cmd_i.miss ? 4'd0 : 4'(unsigned'(cur_q[1]));
  assign cell_z_o     = cmd_i.miss ? 4'd0 : 4'(unsigned'(cur_q[2]));
  assign cell_index_o = cmd_i.miss ? 12'd0 : idx[11:0];
  assign last_o       = cmd_i.miss || sts_o.walk_last;

endmodule

FILE: rtl/uwr_ctrl.sv
// Controller state machine that sequences setup and the cell walk of one ray.
module uwr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  uwr_pkg::dp_sts_t sts_i,
  output uwr_pkg::dp_cmd_t cmd_o
);
  import uwr_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE     = 15'h0001,
    S_AX_CHK   = 15'h0002,
    S_DIV_LO   = 15'h0004,
    S_DIV_HI   = 15'h0008,
    S_TEST     = 15'h0010,
    S_MUL_LO   = 15'h0020,
    S_MUL_HI   = 15'h0040,
    S_OFF      = 15'h0080,
    S_CELL_ST  = 15'h0100,
    S_CELL_DIV = 15'h0200,
    S_DT_ST    = 15'h0400,
    S_DT_DIV   = 15'h0800,
    S_NXT      = 15'h1000,
    S_WALK     = 15'h2000,
    S_MISS     = 15'h4000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] ax_q, ax_d;

  always_comb begin
    state_d     = state_q;
    ax_d        = ax_q;
    cmd_o       = '0;
    cmd_o.ax    = ax_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          ax_d       = 2'd0;
          state_d    = S_AX_CHK;
        end
      end
      S_AX_CHK: begin
        if (sts_i.ax_miss) begin
          state_d = S_MISS;
        end else if (sts_i.d_zero) begin
          cmd_o.set_inf = 1'b1;
          if (ax_q == 2'd2) state_d = S_TEST;
          else              ax_d    = ax_q + 1'b1;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.sel       = DIV_SLAB_LO;
          state_d         = S_DIV_LO;
        end
      end
      S_DIV_LO: begin
        if (sts_i.div_done) begin
          cmd_o.wr_a      = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.sel       = DIV_SLAB_HI;
          state_d         = S_DIV_HI;
        end
      end
      S_DIV_HI: begin
        if (sts_i.div_done) begin
          cmd_o.wr_slab = 1'b1;
          if (ax_q == 2'd2) begin
            state_d = S_TEST;
          end else begin
            ax_d    = ax_q + 1'b1;
            state_d = S_AX_CHK;
          end
        end
      end
      S_TEST: begin
        if (sts_i.t_miss) begin
          state_d = S_MISS;
        end else begin
          cmd_o.wr_te = 1'b1;
          ax_d        = 2'd0;
          state_d     = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_OFF;
      end
      S_OFF: begin
        cmd_o.wr_off = 1'b1;
        state_d      = S_CELL_ST;
      end
      S_CELL_ST: begin
        cmd_o.sel = DIV_CELL;
        if (!sts_i.off_pos) begin
          cmd_o.cur_zero = 1'b1;
          if (ax_q == 2'd2) begin
            ax_d    = 2'd0;
            state_d = S_DT_ST;
          end else begin
            ax_d    = ax_q + 1'b1;
            state_d = S_MUL_LO;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_CELL_DIV;
        end
      end
      S_CELL_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.wr_cur = 1'b1;
          if (ax_q == 2'd2) begin
            ax_d    = 2'd0;
            state_d = S_DT_ST;
          end else begin
            ax_d    = ax_q + 1'b1;
            state_d = S_MUL_LO;
          end
        end
      end
      S_DT_ST: begin
        cmd_o.sel = DIV_DT;
        if (sts_i.d_zero) begin
          cmd_o.dt_idle = 1'b1;
          if (ax_q == 2'd2) state_d = S_WALK;
          else              ax_d    = ax_q + 1'b1;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DT_DIV;
        end
      end
      S_DT_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.wr_dt = 1'b1;
          state_d     = S_NXT;
        end
      end
      S_NXT: begin
        cmd_o.wr_nxt = 1'b1;
        if (ax_q == 2'd2) begin
          state_d = S_WALK;
        end else begin
          ax_d    = ax_q + 1'b1;
          state_d = S_DT_ST;
        end
      end
      S_WALK: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (sts_i.walk_last) state_d    = S_IDLE;
          else                 cmd_o.step = 1'b1;
        end
      end
      S_MISS: begin
        out_valid_o = 1'b1;
        cmd_o.miss  = 1'b1;
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ax_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      ax_q    <= ax_d;
    end
  end

endmodule

FILE: test/uniform_grid_ray_walker_tb.sv
// Self-checking testbench for the uniform grid ray walker: directed and random rays, random boxes and stalls.
`timescale 1ns / 100ps

module uniform_grid_ray_walker_tb;
  import uwr_pkg::*;

  localparam int  CAP_CELLS = 46;
  localparam int  IDLE_LIMIT = 20000;
  localparam longint FIX_ONE = 64'sd65536;
  localparam longint T_BIG = 64'sh4000_0000_0000_0000;

  typedef struct packed {
    logic        hit;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  z;
    logic [11:0] idx;
    logic        last;
  } cell_t;

  class walk_tracker;
    logic [31:0] regs[7];
    cell_t       cells_q[$];

    function new();
      regs[REG_BOX_LO_X] = 0;
      regs[REG_BOX_LO_Y] = 0;
      regs[REG_BOX_LO_Z] = 0;
      regs[REG_BOX_HI_X] = 65536;
      regs[REG_BOX_HI_Y] = 65536;
      regs[REG_BOX_HI_Z] = 65536;
      regs[REG_GRID_DIMS] = 1057;
    endfunction

    function void write_reg(int idx, logic [31:0] v);
      regs[idx] = (idx == REG_GRID_DIMS) ? (v & 32'h7fff) : v;
    endfunction

    function void push_cell(bit hit, int cx, int cy, int cz, int nx, int ny);
      cell_t c;
      c.hit = hit;
      c.x = cx[3:0];
      c.y = cy[3:0];
      c.z = cz[3:0];
      c.idx = 12'(cx + nx * cy + nx * ny * cz);
      c.last = 1'b0;
      cells_q = {cells_q, c};
    endfunction

    function void note_ray(logic signed [31:0] org[3], logic signed [31:0] dirv[3]);
      longint o[3], d[3], lo[3], hi[3], tmn[3], tmx[3], nxt[3], dt[3];
      longint t0, t1, te, w, off, q;
      int n[3], cur[3], stp[3], stop_at[3];
      int count, ax;
      bit any;
      t0 = -T_BIG;
      t1 = T_BIG;
      any = 0;
      for (int a = 0; a < 3; a++) begin
        o[a] = org[a];
        d[a] = dirv[a];
        lo[a] = $signed(regs[a]);
        hi[a] = $signed(regs[3 + a]);
        n[a] = ((regs[REG_GRID_DIMS] >> (5 * a)) & 31) + 1;
        if (n[a] > 16) n[a] = 16;
      end
      for (int a = 0; a < 3; a++) begin
        if (hi[a] <= lo[a] || (d[a] == 0 && (o[a] < lo[a] || o[a] > hi[a]))) begin
          push_cell(0, 0, 0, 0, 1, 1);
          cells_q[$].last = 1'b1;
          return;
        end
        if (d[a] == 0) begin
          tmn[a] = -T_BIG;
          tmx[a] = T_BIG;
        end else if (d[a] > 0) begin
          tmn[a] = (lo[a] - o[a]) * FIX_ONE / d[a];
          tmx[a] = (hi[a] - o[a]) * FIX_ONE / d[a];
        end else begin
          tmn[a] = (hi[a] - o[a]) * FIX_ONE / d[a];
          tmx[a] = (lo[a] - o[a]) * FIX_ONE / d[a];
        end
        if (tmn[a] > t0) t0 = tmn[a];
        if (tmx[a] < t1) t1 = tmx[a];
      end
      if (t0 > t1 || t1 < 0) begin
        push_cell(0, 0, 0, 0, 1, 1);
        cells_q[$].last = 1'b1;
        return;
      end
      te = (t0 > 0) ? t0 : 0;
      for (int a = 0; a < 3; a++) begin
        w = (hi[a] - lo[a]) * FIX_ONE;
        off = (o[a] - lo[a]) * FIX_ONE + te * d[a];
        q = (off <= 0) ? 0 : off * n[a] / w;
        if (q > n[a] - 1) q = n[a] - 1;
        cur[a] = int'(q);
        if (d[a] != 0) begin
          any = 1;
          dt[a] = (tmx[a] - tmn[a]) / n[a];
          if (d[a] > 0) begin
            nxt[a] = tmn[a] + longint'(cur[a] + 1) * dt[a];
            stp[a] = 1;
            stop_at[a] = n[a];
          end else begin
            nxt[a] = tmn[a] + longint'(n[a] - cur[a]) * dt[a];
            stp[a] = -1;
            stop_at[a] = -1;
          end
        end else begin
          nxt[a] = T_BIG;
          dt[a] = 0;
          stp[a] = 0;
          stop_at[a] = -1;
        end
      end
      count = 0;
      forever begin
        push_cell(1, cur[0], cur[1], cur[2], n[0], n[1]);
        count++;
        if (!any || count >= CAP_CELLS) begin
          cells_q[$].last = 1'b1;
          break;
        end
        if (nxt[0] < nxt[1] && nxt[0] < nxt[2]) ax = 0;
        else if (nxt[1] < nxt[2]) ax = 1;
        else ax = 2;
        nxt[ax] += dt[ax];
        cur[ax] += stp[ax];
        if (cur[ax] == stop_at[ax] || cur[ax] < 0 || cur[ax] >= n[ax]) begin
          cells_q[$].last = 1'b1;
          break;
        end
      end
    endfunction

    function bit check_cell(cell_t got, output string msg);
      cell_t e;
      if (cells_q.size() == 0) begin
        msg = $sformatf("unexpected result %p", got);
        return 0;
      end
      e = cells_q.pop_front();
      msg = "";
      if (got.hit !== e.hit) msg = {msg, $sformatf(" box_hit %0b/%0b", got.hit, e.hit)};
      if (got.x !== e.x) msg = {msg, $sformatf(" cell_x %0d/%0d", got.x, e.x)};
      if (got.y !== e.y) msg = {msg, $sformatf(" cell_y %0d/%0d", got.y, e.y)};
      if (got.z !== e.z) msg = {msg, $sformatf(" cell_z %0d/%0d", got.z, e.z)};
      if (got.idx !== e.idx) msg = {msg, $sformatf(" cell_index %0d/%0d", got.idx, e.idx)};
      if (got.last !== e.last) msg = {msg, $sformatf(" last %0b/%0b", got.last, e.last)};
      return msg == "";
    endfunction

    function int pending();
      return cells_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [REG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [31:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic box_hit_o, last_o;
  logic [3:0] cell_x_o, cell_y_o, cell_z_o;
  logic [11:0] cell_index_o;

  walk_tracker tracker = new();
  int errors = 0;
  int idle_cycles = 0;
  bit no_gaps = 0;
  bit no_stalls = 0;
  int stall_left = 0;
  longint box_lo[3], box_hi[3];

  uniform_grid_ray_walker dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .origin_x_i, .origin_y_i, .origin_z_i, .dir_x_i, .dir_y_i, .dir_z_i,
    .out_valid_o, .out_stall_i,
    .box_hit_o, .cell_x_o, .cell_y_o, .cell_z_o, .cell_index_o, .last_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report(string msg);
    $display("mismatch at %0t:%s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk_i) begin
    logic signed [31:0] org[3], dirv[3];
    cell_t got;
    string msg;
    bit busy;
    busy = 0;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      org = '{origin_x_i, origin_y_i, origin_z_i};
      dirv = '{dir_x_i, dir_y_i, dir_z_i};
      tracker.note_ray(org, dirv);
      busy = 1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{box_hit_o, cell_x_o, cell_y_o, cell_z_o, cell_index_o, last_o};
      if (!tracker.check_cell(got, msg)) report(msg);
      busy = 1;
    end
    idle_cycles = busy ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("uniform_grid_ray_walker_tb: errors");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    int r;
    if (stall_left == 0) begin
      r = $urandom_range(0, 9);
      if (no_stalls || r < 5) begin
        out_stall_i <= 1'b0;
        stall_left = $urandom_range(1, 30);
      end else begin
        out_stall_i <= 1'b1;
        stall_left = (r < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
    end else begin
      stall_left--;
    end
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    tracker.write_reg(idx, v);
    if (idx < REG_BOX_HI_X) box_lo[idx] = $signed(v);
    else if (idx < REG_GRID_DIMS) box_hi[idx - REG_BOX_HI_X] = $signed(v);
    @(negedge clk_i);
  endtask

  task automatic set_box(logic [31:0] lo[3], logic [31:0] hi[3], logic [14:0] dims);
    for (int a = 0; a < 3; a++) begin
      write_cfg(CFG_IDX_W'(REG_BOX_LO_X + a), lo[a]);
      write_cfg(CFG_IDX_W'(REG_BOX_HI_X + a), hi[a]);
    end
    write_cfg(REG_GRID_DIMS, 32'(dims));
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic send_ray(logic [31:0] ox, oy, oz, dx, dy, dz);
    int r, gap;
    in_valid_i <= 1'b1;
    origin_x_i <= ox;
    origin_y_i <= oy;
    origin_z_i <= oz;
    dir_x_i <= dx;
    dir_y_i <= dy;
    dir_z_i <= dz;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    r = $urandom_range(0, 9);
    gap = (no_gaps || r < 6) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_origin(int a);
    longint v, w;
    int r;
    r = $urandom_range(0, 9);
    w = box_hi[a] - box_lo[a];
    if (r == 0) return $urandom;
    if (w <= 0) v = box_lo[a] + $signed($urandom_range(0, 65536)) - 32768;
    else if (r < 7) v = box_lo[a] + (longint'({$urandom, $urandom}) & 64'h7fff_ffff_ffff) % (w + 1);
    else if (r < 9) v = box_lo[a] - longint'($urandom_range(0, 1 << 20));
    else v = box_hi[a] + longint'($urandom_range(0, 1 << 20));
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic logic [31:0] pick_dir();
    int r;
    logic [31:0] m;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return $urandom;
    m = ($urandom >> $urandom_range(6, 24)) + 1;
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  task automatic random_rays(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (i % 40 == 20) no_stalls = ($urandom_range(0, 3) == 0);
      send_ray(pick_origin(0), pick_origin(1), pick_origin(2), pick_dir(), pick_dir(),
               pick_dir());
    end
    no_gaps = 0;
    no_stalls = 0;
  endtask

  task automatic random_box();
    logic [31:0] lo[3], hi[3];
    for (int a = 0; a < 3; a++) begin
      lo[a] = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      hi[a] = lo[a] + $urandom_range(1, 1 << 21);
    end
    set_box(lo, hi, 15'($urandom));
  endtask

  initial begin
    logic [31:0] lo[3], hi[3];
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] HALF = 32'h0000_8000;
    localparam logic [31:0] MINV = 32'h8000_0000;
    localparam logic [31:0] MAXV = 32'h7fff_ffff;
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = 0;
      box_hi[a] = 65536;
    end
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rays on the reset box: unit cube split in two cells per axis.
    send_ray(HALF / 2, HALF / 2, HALF / 2, ONE, 0, 0);
    send_ray(HALF / 2, HALF / 2, HALF / 2, -ONE, 0, 0);
    send_ray(HALF / 2, HALF / 2, HALF / 2, 0, ONE, 0);
    send_ray(HALF / 2, HALF / 2, HALF / 2, 0, 0, -ONE);
    send_ray(HALF / 2, HALF / 2, HALF / 2, 0, 0, 0);
    send_ray(2 * ONE, HALF, HALF, 0, 0, 0);
    send_ray(-ONE, -ONE, -ONE, ONE, ONE, ONE);
    send_ray(-ONE, HALF / 2, -ONE, ONE, 0, ONE);
    send_ray(HALF / 2, -ONE, -ONE, 0, ONE, ONE);
    send_ray(2 * ONE, HALF, HALF, ONE, 0, 0);
    send_ray(-ONE, 2 * ONE, HALF, ONE, 0, 0);
    send_ray(-ONE, HALF, HALF, ONE, 32'h0000_1234, -32'h0000_0777);
    send_ray(MINV, MINV, MINV, MAXV, MAXV, MAXV);
    send_ray(MAXV, MAXV, MAXV, MINV, MINV, MINV);
    send_ray(MINV, HALF, HALF, 1, 0, 0);
    send_ray(MAXV, HALF, HALF, -1, 0, 0);
    send_ray(HALF, HALF, HALF, MAXV, MINV, 1);
    send_ray(ONE, ONE, ONE, -1, -1, -1);
    send_ray(0, 0, 0, 0, 0, 0);
    send_ray(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, 1);
    random_rays(60);
    wait_idle();

    lo = '{MINV, MINV, MINV};
    hi = '{MAXV, MAXV, MAXV};
    set_box(lo, hi, 15'h7fff);
    send_ray(0, 0, 0, MAXV, MAXV, MAXV);
    send_ray(MINV, MINV, MINV, 1, 1, 1);
    random_rays(60);
    wait_idle();

    lo = '{0, 0, 0};
    hi = '{ONE, ONE, ONE};
    set_box(lo, hi, 15'h0);
    random_rays(40);
    wait_idle();

    lo = '{ONE, -ONE, 0};
    hi = '{ONE, ONE, 4 * ONE};
    set_box(lo, hi, 15'h3def);
    random_rays(30);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      random_box();
      random_rays(50);
      wait_idle();
    end

    repeat (200) @(negedge clk_i);
    if (errors == 0 && tracker.pending() == 0) begin
      $display("uniform_grid_ray_walker_tb: clean");
    end else begin
      $display("uniform_grid_ray_walker_tb: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/uwr_pkg.sv
rtl/uwr_div.sv
rtl/uwr_dp.sv
rtl/uwr_ctrl.sv
rtl/uniform_grid_ray_walker.sv
test/uniform_grid_ray_walker_tb.sv
